>>> sv/rmst_pkg.sv
// shared types, constants and compare function of the range minimum sparse table
`default_nettype none

package rmst_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int DATA_W      = 64;
  localparam int RANGE_W     = 13;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_L0,
    ST_APP_LVL,
    ST_Q_CHK,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_MIN,
    ST_Q_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic app_start;
    logic qry_start;
    logic app_l0;
    logic app_lvl;
    logic q_chk;
    logic q_rd0;
    logic q_rd1;
    logic q_min;
    logic q_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic app_more;
    logic q_bad;
    logic out_free;
  } sts_t;

  // sign-magnitude pattern mapped to an unsigned order, both zeros equal
  function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] key;
    if (x[DATA_W-2:0] == '0) begin
      key = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (x[DATA_W-1]) begin
      key = ~x;
    end else begin
      key = x | {1'b1, {(DATA_W-1){1'b0}}};
    end
    return key;
  endfunction

  // smaller of two patterns, first wins a tie
  function automatic logic [DATA_W-1:0] pick_min(input logic [DATA_W-1:0] first,
                                                 input logic [DATA_W-1:0] second);
    return (order_key(second) < order_key(first)) ? second : first;
  endfunction

endpackage

`default_nettype wire

>>> sv/rmst_ctrl.sv
// control state machine of the range minimum sparse table
`default_nettype none

module rmst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          operation,
  output logic                     in_stall,
  input  wire rmst_pkg::sts_t      sts,
  output rmst_pkg::cmd_t           cmd
);

  rmst_pkg::state_t state;
  rmst_pkg::state_t state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && (state == rmst_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      rmst_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (operation)
            rmst_pkg::OP_APPEND: begin
              if (!sts.full) begin
                state_next = rmst_pkg::ST_APP_L0;
              end
            end
            rmst_pkg::OP_QUERY: state_next = rmst_pkg::ST_Q_CHK;
            default:            state_next = rmst_pkg::ST_IDLE;
          endcase
        end
      end
      rmst_pkg::ST_APP_L0,
      rmst_pkg::ST_APP_LVL: begin
        state_next = sts.app_more ? rmst_pkg::ST_APP_LVL : rmst_pkg::ST_IDLE;
      end
      rmst_pkg::ST_Q_CHK: begin
        state_next = sts.q_bad ? rmst_pkg::ST_Q_OUT : rmst_pkg::ST_Q_RD0;
      end
      rmst_pkg::ST_Q_RD0: state_next = rmst_pkg::ST_Q_RD1;
      rmst_pkg::ST_Q_RD1: state_next = rmst_pkg::ST_Q_MIN;
      rmst_pkg::ST_Q_MIN: state_next = rmst_pkg::ST_Q_OUT;
      rmst_pkg::ST_Q_OUT: begin
        if (sts.out_free) begin
          state_next = rmst_pkg::ST_IDLE;
        end
      end
      default: state_next = rmst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != rmst_pkg::ST_IDLE);
    unique case (state)
      rmst_pkg::ST_IDLE: begin
        cmd.clear     = accept && (operation == rmst_pkg::OP_CLEAR);
        cmd.app_start = accept && (operation == rmst_pkg::OP_APPEND) && !sts.full;
        cmd.qry_start = accept && (operation == rmst_pkg::OP_QUERY);
      end
      rmst_pkg::ST_APP_L0:  cmd.app_l0  = 1'b1;
      rmst_pkg::ST_APP_LVL: cmd.app_lvl = 1'b1;
      rmst_pkg::ST_Q_CHK:   cmd.q_chk   = 1'b1;
      rmst_pkg::ST_Q_RD0:   cmd.q_rd0   = 1'b1;
      rmst_pkg::ST_Q_RD1:   cmd.q_rd1   = 1'b1;
      rmst_pkg::ST_Q_MIN:   cmd.q_min   = 1'b1;
      rmst_pkg::ST_Q_OUT:   cmd.q_load  = sts.out_free;
      default:              cmd         = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/rmst_dp.sv
// datapath of the range minimum sparse table: level memory, counters, output word
`default_nettype none

module rmst_dp #(
  parameter int MAX_LEN = rmst_pkg::MAX_LEN_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rmst_pkg::cmd_t                        cmd,
  output rmst_pkg::sts_t                             sts,
  input  wire logic [rmst_pkg::DATA_W-1:0]           value,
  input  wire logic [rmst_pkg::RANGE_W-1:0]          range_start,
  input  wire logic [rmst_pkg::RANGE_W-1:0]          range_end,
  input  wire logic                                  cfg_we,
  input  wire logic [rmst_pkg::DATA_W-1:0]           cfg_data,
  input  wire logic                                  out_stall,
  output logic                                       out_valid,
  output logic [rmst_pkg::DATA_W-1:0]                minimum,
  output logic                                       out_of_range
);

  localparam int DW     = rmst_pkg::DATA_W;
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int LEVELS = CNT_W;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CW     = (CNT_W > rmst_pkg::RANGE_W) ? CNT_W : rmst_pkg::RANGE_W;
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = LEVELS << IDX_W;

  logic [DW-1:0]     mem [DEPTH];
  logic [DW-1:0]     rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DW-1:0]     wr_data;
  logic              wr_en;

  logic [CNT_W-1:0]  count;
  logic [DW-1:0]     outside;
  logic [DW-1:0]     val_q;
  logic [DW-1:0]     prev;
  logic [LVL_W-1:0]  lvl;
  logic [IDX_W-1:0]  wstart;
  logic [CNT_W:0]    span;
  logic [IDX_W-1:0]  half;

  logic [CW-1:0]     qa;
  logic [CW-1:0]     qb;
  logic [CW-1:0]     qlen;
  logic [LVL_W-1:0]  k_enc;
  logic [LVL_W-1:0]  qk;
  logic [IDX_W-1:0]  qa_idx;
  logic [IDX_W-1:0]  qb_idx;
  logic [DW-1:0]     first;
  logic [DW-1:0]     res;
  logic              flag;

  // level memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign half    = IDX_W'(span >> 1);
  assign wr_en   = cmd.app_l0 || cmd.app_lvl;
  assign wr_addr = {lvl, wstart};
  assign wr_data = cmd.app_l0 ? val_q : rmst_pkg::pick_min(rd_data, prev);

  // fetch the older half for the next level while this one is written
  always_comb begin
    if (cmd.q_rd0) begin
      rd_addr = {qk, qa_idx};
    end else if (cmd.q_rd1) begin
      rd_addr = {qk, qb_idx};
    end else begin
      rd_addr = {lvl, wstart - half};
    end
  end

  assign qlen = qb - qa + CW'(1);

  always_comb begin
    k_enc = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (qlen[i]) begin
        k_enc = LVL_W'(i);
      end
    end
  end

  assign sts.full     = (count == CNT_W'(MAX_LEN));
  assign sts.app_more = (span <= {1'b0, count});
  assign sts.q_bad    = (qb < qa) || (qb >= CW'(count));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      outside <= '0;
    end else begin
      if (cfg_we) begin
        outside <= cfg_data;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.app_start) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // append walk over the levels
  always_ff @(posedge clk) begin
    if (cmd.app_start) begin
      val_q  <= value;
      lvl    <= '0;
      wstart <= count[IDX_W-1:0];
      span   <= (CNT_W + 1)'(2);
    end else if (wr_en) begin
      prev   <= wr_data;
      lvl    <= lvl + LVL_W'(1);
      wstart <= wstart - half;
      span   <= span << 1;
    end
  end

  // query
  always_ff @(posedge clk) begin
    if (cmd.qry_start) begin
      qa <= CW'(range_start);
      qb <= CW'(range_end);
    end
    if (cmd.q_chk) begin
      qk     <= k_enc;
      qa_idx <= qa[IDX_W-1:0];
      qb_idx <= IDX_W'(qb + CW'(1) - (CW'(1) << k_enc));
      res    <= outside;
      flag   <= 1'b1;
    end
    if (cmd.q_rd1) begin
      first <= rd_data;
    end
    if (cmd.q_min) begin
      res  <= rmst_pkg::pick_min(first, rd_data);
      flag <= 1'b0;
    end
    if (cmd.q_load) begin
      minimum      <= res;
      out_of_range <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.q_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/range_minimum_sparse_table.sv
// top level of the range minimum sparse table
// usage:
// - input channel (in_valid / in_stall) takes one word per item: operation clear,
//   append or query, with value for an append and range_start / range_end for a query
// - output channel (out_valid / out_stall) gives one word per query: minimum and
//   out_of_range; clear and append give nothing, operation code 3 is dropped
// - cfg channel (cfg_valid / cfg_ready, always ready) writes the outside value that an
//   empty or out of bounds query returns; write it only while the block is idle
// - clear empties the table as it is accepted; an append writes level zero, then each
//   level k with 2^k <= n (n the new element count), one level of the table per cycle
//   on the single write port of the level memory; an append to a full table is dropped
// - a query does a range check, two reads of the one memory read port, a compare and
//   the output load; an invalid range goes from the check straight to the output load
// - one item is worked on at a time; in_stall is high until that item is done
// - the result sits in an output register; while out_stall holds it, the next
//   items are still taken and only a further query waits for the register
// - rst (synchronous) empties the table and sets the outside value to zero;
//   memory contents are not cleared, an entry is used only after an append wrote it
`default_nettype none

module range_minimum_sparse_table #(
  parameter int MAX_LEN = rmst_pkg::MAX_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rmst_pkg::OP_W-1:0]         operation,
  input  wire logic [rmst_pkg::DATA_W-1:0]       value,
  input  wire logic [rmst_pkg::RANGE_W-1:0]      range_start,
  input  wire logic [rmst_pkg::RANGE_W-1:0]      range_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rmst_pkg::DATA_W-1:0]            minimum,
  output logic                                   out_of_range,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rmst_pkg::DATA_W-1:0]       cfg_data
);

  rmst_pkg::cmd_t cmd;
  rmst_pkg::sts_t sts;

  // register write is a single flop load, never blocked
  assign cfg_ready = 1'b1;

  rmst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmst_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .range_start  (range_start),
    .range_end    (range_end),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .minimum      (minimum),
    .out_of_range (out_of_range)
  );

`ifndef SYNTHESIS
  // an accepted append to a table with room starts the level walk next cycle
  a_app_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.app_start |=> cmd.app_l0)
    else $error("append did not start the level walk");

  // upper levels only follow level zero or a previous level
  a_lvl_order: assert property (@(posedge clk) disable iff (rst)
    cmd.app_lvl |-> $past(cmd.app_l0 || cmd.app_lvl))
    else $error("level write out of sequence");

  // the output register is never overwritten while a word is stalled in it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.q_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled word");

  // a finished compare is delivered as soon as the output register is free
  a_load_after_min: assert property (@(posedge clk) disable iff (rst)
    cmd.q_min |=> (cmd.q_load == sts.out_free))
    else $error("query result not loaded when output free");
`endif

endmodule

`default_nettype wire

>>> dv/tb_range_minimum_sparse_table.sv
// testbench of the range minimum sparse table: predicted minima checked against every query
`timescale 1ns / 100ps

class range_min_tracker;
  localparam int TABLE_LEN = rmst_pkg::MAX_LEN_DEF;
  localparam int LEVELS = $clog2(TABLE_LEN) + 1;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] minimum;
    logic        out_of_range;
  } min_word_t;

  // entry of level k at start s: minimum of elements s .. s+2^k-1
  logic [63:0] span_min [LEVELS][TABLE_LEN];
  int unsigned stored = 0;
  logic [63:0] outside = '0;
  min_word_t   expected_minima [$];

  int mismatches = 0;
  int queries = 0;
  int outside_hits = 0;
  int appends = 0;
  int dropped = 0;
  int clears = 0;
  int reserved = 0;
  int deepest = 0;

  // sign-magnitude pattern to unsigned order, both zeros equal
  function logic [63:0] rank(logic [63:0] x);
    if (x[62:0] == '0) return SIGN_BIT;
    if (x[63]) return ~x;
    return {1'b1, x[62:0]};
  endfunction

  // first operand kept on a tie
  function logic [63:0] lesser(logic [63:0] first, logic [63:0] second);
    return (rank(second) < rank(first)) ? second : first;
  endfunction

  function int pending();
    return expected_minima.size();
  endfunction

  task flag_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function void note_input(logic [1:0] op, logic [63:0] val, logic [12:0] a,
                           logic [12:0] b);
    int unsigned pos;
    int unsigned start;
    int unsigned len;
    int unsigned k;
    min_word_t   res;
    case (op)
      rmst_pkg::OP_CLEAR: begin
        stored = 0;
        clears++;
      end
      rmst_pkg::OP_APPEND: begin
        appends++;
        if (stored >= TABLE_LEN) begin
          dropped++;
        end else begin
          pos = stored;
          span_min[0][pos] = val;
          for (k = 1; k < LEVELS && (1 << k) <= pos + 1; k++) begin
            start = pos + 1 - (1 << k);
            span_min[k][start] = lesser(span_min[k-1][start],
                                        span_min[k-1][start + (1 << (k - 1))]);
          end
          stored = pos + 1;
        end
      end
      rmst_pkg::OP_QUERY: begin
        queries++;
        if (b < a || b >= stored) begin
          res.minimum = outside;
          res.out_of_range = 1'b1;
          outside_hits++;
        end else begin
          len = b - a + 1;
          k = 0;
          while (k + 1 < LEVELS && (1 << (k + 1)) <= len) k++;
          res.minimum = lesser(span_min[k][a], span_min[k][b + 1 - (1 << k)]);
          res.out_of_range = 1'b0;
          if (k > deepest) deepest = k;
        end
        expected_minima = {expected_minima, res};
      end
      default: reserved++;
    endcase
  endfunction

  task check_result(logic [63:0] got_min, logic got_flag);
    min_word_t want;
    if (expected_minima.size() == 0) begin
      flag_mismatch($sformatf("result %h / %b with no query waiting", got_min, got_flag));
      return;
    end
    want = expected_minima.pop_front();
    if (got_min !== want.minimum)
      flag_mismatch($sformatf("minimum %h, predicted %h", got_min, want.minimum));
    if (got_flag !== want.out_of_range)
      flag_mismatch($sformatf("out_of_range %b, predicted %b", got_flag, want.out_of_range));
  endtask
endclass

module tb_range_minimum_sparse_table;

  // operation code the block must drop
  localparam logic [rmst_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  // idle cycles after the last result, enough to cover a trailing append
  localparam int SETTLE_CYCLES = 20;
  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 4000;

  // corner patterns: zeros, infinities, nans, extremes of the order, tiny magnitudes
  localparam logic [63:0] EDGE_PATTERNS [10] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF8_0000_0000_0000, 64'hFFF8_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel, all driven to known values from time zero
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [rmst_pkg::OP_W-1:0]         operation = '0;
  logic [rmst_pkg::DATA_W-1:0]       value = '0;
  logic [rmst_pkg::RANGE_W-1:0]      range_start = '0;
  logic [rmst_pkg::RANGE_W-1:0]      range_end = '0;

  // result channel
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [rmst_pkg::DATA_W-1:0]       minimum;
  logic                              out_of_range;

  // register write channel
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rmst_pkg::DATA_W-1:0]       cfg_data = '0;

  range_min_tracker tracker = new();

  // percent of cycles in which each side holds off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int outside_writes = 0;

  range_minimum_sparse_table dut (
    .clk, .rst,
    .in_valid, .in_stall, .operation, .value, .range_start, .range_end,
    .out_valid, .out_stall, .minimum, .out_of_range,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // mostly random patterns, some corner patterns, some from a narrow pool so ties happen
  function automatic logic [63:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return EDGE_PATTERNS[$urandom_range(9)];
    if (r <= 2) return {1'($urandom), 11'h3FF, 49'd0, 3'($urandom)};
    return {$urandom, $urandom};
  endfunction

  // receiver: stall decided at the falling edge, result taken at the rising edge
  always @(negedge clk) out_stall <= roll(recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(minimum, out_of_range);
  end

  // hang detection: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("tb_range_minimum_sparse_table NOT OK");
      $finish;
    end
  end

  // one word on the input channel; valid stays up after acceptance until the next falling
  // edge, where the next call or a pause decides its level, so it is assigned once per step
  task automatic drive_item(logic [rmst_pkg::OP_W-1:0] op, logic [63:0] val,
                            logic [12:0] a, logic [12:0] b);
    @(negedge clk);
    while (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    value       <= val;
    range_start <= a;
    range_end   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(op, val, a, b);
  endtask

  task automatic append_value(logic [63:0] val);
    drive_item(rmst_pkg::OP_APPEND, val, 13'($urandom), 13'($urandom));
  endtask

  task automatic ask_range(logic [12:0] a, logic [12:0] b);
    drive_item(rmst_pkg::OP_QUERY, {$urandom, $urandom}, a, b);
  endtask

  task automatic drop_table();
    drive_item(rmst_pkg::OP_CLEAR, {$urandom, $urandom}, 13'($urandom), 13'($urandom));
  endtask

  // sender holds off until every query has answered and a trailing append is done
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // outside value written only with the block idle
  task automatic write_outside(logic [63:0] val);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.outside = val;
    outside_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // query ranges: mostly inside the table, some whole table, the rest empty, past the end or random
  task automatic pick_range(output logic [12:0] a, output logic [12:0] b);
    int unsigned n;
    int unsigned r;
    n = tracker.stored;
    r = $urandom_range(99);
    if (n != 0 && r < 70) begin
      a = 13'($urandom_range(n - 1));
      b = 13'($urandom_range(n - 1, a));
    end else if (n != 0 && r < 80) begin
      a = '0;
      b = 13'(n - 1);
    end else if (r < 88) begin
      a = 13'($urandom_range(8191, 1));
      b = 13'($urandom_range(a - 1));
    end else if (r < 95) begin
      a = 13'($urandom);
      b = 13'($urandom_range(8191, n));
    end else begin
      a = 13'($urandom);
      b = 13'($urandom);
    end
  endtask

  task automatic random_items(int n);
    int unsigned r;
    logic [12:0] a;
    logic [12:0] b;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        drop_table();
      end else if (r < 6) begin
        drive_item(OP_RESERVED, {$urandom, $urandom}, 13'($urandom), 13'($urandom));
      end else if (r < 52) begin
        append_value(pick_value());
      end else begin
        pick_range(a, b);
        ask_range(a, b);
      end
      // now and then the sender waits for every answer
      if (roll(2)) wait_quiet();
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // phase one: sender idles lightly, receiver stalls often
    send_idle_pct = 10;
    recv_idle_pct = 56;
    write_outside(64'hFFFF_FFFF_FFFF_FFFF);

    // directed: empty table, reserved code, signed zeros tie, corner patterns
    ask_range(0, 0);
    drive_item(OP_RESERVED, {$urandom, $urandom}, 13'($urandom), 13'($urandom));
    append_value(EDGE_PATTERNS[0]);
    append_value(EDGE_PATTERNS[1]);
    ask_range(0, 1);
    ask_range(1, 1);
    for (int i = 2; i < 10; i++) append_value(EDGE_PATTERNS[i]);
    ask_range(0, 9);
    ask_range(0, 7);
    ask_range(2, 4);
    ask_range(8, 9);
    // end before start, end at the count, both at the top of the index range
    ask_range(5, 4);
    ask_range(0, 10);
    ask_range(8191, 8191);
    drop_table();
    ask_range(0, 0);
    append_value(64'hFFFF_FFFF_FFFF_FFFF);
    ask_range(0, 0);

    write_outside(64'h0000_0000_0000_0000);
    random_items(140);

    // phase two: sender idles often, receiver stalls lightly
    wait_quiet();
    send_idle_pct = 56;
    recv_idle_pct = 10;
    write_outside({$urandom, $urandom});
    random_items(140);

    // phase three: full rate on both sides
    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_outside(64'h8000_0000_0000_0000);
    random_items(140);

    wait_quiet();
    if (tracker.pending() != 0)
      tracker.flag_mismatch($sformatf("%0d queries never answered", tracker.pending()));

    $display("covered %0d appends (%0d dropped at capacity), %0d clears, %0d reserved codes",
             tracker.appends, tracker.dropped, tracker.clears, tracker.reserved);
    $display("%0d queries (%0d outside), deepest level %0d, %0d outside value writes",
             tracker.queries, tracker.outside_hits, tracker.deepest, outside_writes);
    if (tracker.mismatches == 0)
      $display("tb_range_minimum_sparse_table OK");
    else
      $display("tb_range_minimum_sparse_table NOT OK");
    $finish;
  end
endmodule
